>>> src/nngs_pkg.sv
`timescale 1ns / 1ps

package nngs_pkg;

  // Field widths of one beat
  localparam int PIX_W   = 8;   // gray value
  localparam int COORD_W = 8;   // source column / row of a load, mapped column / row
  localparam int POS_W   = 12;  // output column / row of a fetch

  // Size register widths
  localparam int SRC_W = 9;
  localparam int DST_W = 13;

  // Mapping arithmetic: pos * src / dst, quotient stays below src
  localparam int PROD_W    = POS_W + SRC_W;
  localparam int Q_W       = SRC_W;
  localparam int DIV_STEPS = Q_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // Stream payload widths
  localparam int IN_DATA_W  = 48;  // 8 + 8 + 8 + 12 + 12
  localparam int OUT_DATA_W = 24;  // 8 + 8 + 8

  // Configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = DST_W;

  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_WIDTH  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HEIGHT = 8'd3;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_FETCH = 1'b1
  } op_t;

  // Controller to datapath
  typedef struct packed {
    logic load_write;
    logic capture;
    logic div_start;
    logic div_step;
    logic mem_read;
    logic out_load;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_last;
    logic out_free;
  } ctrl_stat_t;

endpackage

>>> src/nearest_neighbor_gray_scaler.sv
`timescale 1ns / 1ps
// Load beats: one per cycle while no fetch is in progress, no result beat.
// Fetch beats: one result beat each; no beat is taken until the fetch has run
// through multiply, 9-step restoring divide, store read and hand-over states.
// Reset (rst, synchronous, active high) clears the sequencer and output valid
// and sets all four sizes to 1; the pixel store is not cleared.

module nearest_neighbor_gray_scaler import nngs_pkg::*; #(
  parameter int MAX_SOURCE_WIDTH  = 256,
  parameter int MAX_SOURCE_HEIGHT = 256,
  parameter int MAX_TARGET_SIZE   = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Input beats
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // pixel_in[7:0], source_col[15:8], source_row[23:16],
  // target_col[35:24], target_row[47:36]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tuser,   // operation[0]
  // Result beats
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // pixel_out[7:0], mapped_col[15:8], mapped_row[23:16]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tuser    // in_range[0]
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  assign cfg_ready = 1'b1;

  nngs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_op    (s_axis_tuser),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  nngs_datapath #(
    .MAX_SOURCE_WIDTH  (MAX_SOURCE_WIDTH),
    .MAX_SOURCE_HEIGHT (MAX_SOURCE_HEIGHT),
    .MAX_TARGET_SIZE   (MAX_TARGET_SIZE)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser)
  );

endmodule

>>> src/nngs_div.sv
`timescale 1ns / 1ps

module nngs_div import nngs_pkg::*; (
  input  logic              clk,
  input  logic              start,
  input  logic              step,
  input  logic [PROD_W-1:0] dividend,
  input  logic [DST_W-1:0]  divisor,
  output logic [Q_W-1:0]    quotient
);

  localparam int HI_W = PROD_W - Q_W;

  logic [DST_W-1:0] rem;
  logic [Q_W-1:0]   quo;
  logic [DST_W-1:0] dsr;
  logic [DST_W:0]   trial;
  logic [DST_W:0]   diff;
  logic             fits;

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    trial = {rem, quo[Q_W-1]};
    diff  = trial - {1'b0, dsr};
    fits  = (trial >= {1'b0, dsr});
  end

  // Restoring division, one quotient bit per step; the upper dividend
  // bits are already below the divisor, so only Q_W steps are needed
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= {{(DST_W - HI_W){1'b0}}, dividend[PROD_W-1:Q_W]};
      quo <= dividend[Q_W-1:0];
      dsr <= divisor;
    end else if (step) begin
      rem <= fits ? diff[DST_W-1:0] : trial[DST_W-1:0];
      quo <= {quo[Q_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

>>> src/nngs_datapath.sv
`timescale 1ns / 1ps

module nngs_datapath import nngs_pkg::*; #(
  parameter int MAX_SOURCE_WIDTH  = 256,
  parameter int MAX_SOURCE_HEIGHT = 256,
  parameter int MAX_TARGET_SIZE   = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ctrl_cmd_t             cmd,
  output ctrl_stat_t            stat,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [IN_DATA_W-1:0]  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data,
  output logic                  out_user
);

  localparam int DEPTH  = MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [31:0] ROW_STRIDE = 32'(MAX_SOURCE_WIDTH);

  localparam logic [SRC_W-1:0] SW_CAP =
    (MAX_SOURCE_WIDTH > 511) ? 9'd511 : SRC_W'(MAX_SOURCE_WIDTH);
  localparam logic [SRC_W-1:0] SH_CAP =
    (MAX_SOURCE_HEIGHT > 511) ? 9'd511 : SRC_W'(MAX_SOURCE_HEIGHT);
  localparam logic [DST_W-1:0] DT_CAP =
    (MAX_TARGET_SIZE > 8191) ? 13'd8191 : DST_W'(MAX_TARGET_SIZE);

  // Size registers
  logic [SRC_W-1:0] source_width;
  logic [SRC_W-1:0] source_height;
  logic [DST_W-1:0] target_width;
  logic [DST_W-1:0] target_height;

  logic [SRC_W-1:0] eff_sw;
  logic [SRC_W-1:0] eff_sh;
  logic [DST_W-1:0] eff_tw;
  logic [DST_W-1:0] eff_th;

  // Input beat fields
  logic [PIX_W-1:0]   in_pixel;
  logic [COORD_W-1:0] in_scol;
  logic [COORD_W-1:0] in_srow;
  logic [POS_W-1:0]   in_tcol;
  logic [POS_W-1:0]   in_trow;

  logic [POS_W-1:0]  tcol;
  logic [POS_W-1:0]  trow;
  logic              hit;
  logic [CNT_W-1:0]  step_cnt;
  logic [PROD_W-1:0] col_prod;
  logic [PROD_W-1:0] row_prod;
  logic [Q_W-1:0]    q_col;
  logic [Q_W-1:0]    q_row;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_ok;
  logic [PIX_W-1:0]  rd_pixel;

  logic [PIX_W-1:0] frame_mem [DEPTH];

  logic [PIX_W-1:0]   out_pixel;
  logic               out_flag;
  logic [COORD_W-1:0] out_col;
  logic [COORD_W-1:0] out_row;

  assign {in_trow, in_tcol, in_srow, in_scol, in_pixel} = in_data;

  // Take size registers; unknown indexes fall through
  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= SRC_W'(1);
      source_height <= SRC_W'(1);
      target_width  <= DST_W'(1);
      target_height <= DST_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SOURCE_WIDTH:  source_width  <= cfg_data[SRC_W-1:0];
        CFG_SOURCE_HEIGHT: source_height <= cfg_data[SRC_W-1:0];
        CFG_TARGET_WIDTH:  target_width  <= cfg_data;
        CFG_TARGET_HEIGHT: target_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Zero acts as one, oversize acts as the maximum
  always_comb begin
    eff_sw = (source_width == '0) ? SRC_W'(1)
           : ((source_width > SW_CAP) ? SW_CAP : source_width);
    eff_sh = (source_height == '0) ? SRC_W'(1)
           : ((source_height > SH_CAP) ? SH_CAP : source_height);
    eff_tw = (target_width == '0) ? DST_W'(1)
           : ((target_width > DT_CAP) ? DT_CAP : target_width);
    eff_th = (target_height == '0) ? DST_W'(1)
           : ((target_height > DT_CAP) ? DT_CAP : target_height);
  end

  // Store a source pixel when it lies inside the source frame
  always_comb begin
    wr_ok   = ({1'b0, in_scol} < eff_sw) && ({1'b0, in_srow} < eff_sh);
    wr_addr = ADDR_W'(32'(in_srow) * ROW_STRIDE + 32'(in_scol));
    rd_addr = ADDR_W'(32'(q_row) * ROW_STRIDE + 32'(q_col));
  end

  always_ff @(posedge clk) begin
    if (cmd.load_write && wr_ok) begin
      frame_mem[wr_addr] <= in_pixel;
    end
    if (cmd.mem_read) begin
      rd_pixel <= frame_mem[rd_addr];
    end
  end

  // Hold the fetch coordinate and its range check
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      tcol <= in_tcol;
      trow <= in_trow;
    end
    if (cmd.div_start) begin
      hit <= ({1'b0, tcol} < eff_tw) && ({1'b0, trow} < eff_th);
    end
  end

  // Count divider steps
  always_ff @(posedge clk) begin
    if (rst) begin
      step_cnt <= '0;
    end else if (cmd.div_start) begin
      step_cnt <= '0;
    end else if (cmd.div_step) begin
      step_cnt <= step_cnt + CNT_W'(1);
    end
  end

  // Scale the held coordinate by the source size
  assign col_prod = PROD_W'(tcol) * PROD_W'(eff_sw);
  assign row_prod = PROD_W'(trow) * PROD_W'(eff_sh);

  // Column and row lanes run side by side
  nngs_div u_div_col (
    .clk      (clk),
    .start    (cmd.div_start),
    .step     (cmd.div_step),
    .dividend (col_prod),
    .divisor  (eff_tw),
    .quotient (q_col)
  );

  nngs_div u_div_row (
    .clk      (clk),
    .start    (cmd.div_start),
    .step     (cmd.div_step),
    .dividend (row_prod),
    .divisor  (eff_th),
    .quotient (q_row)
  );

  // Output register; a result waits here while new beats come in
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_pixel <= hit ? rd_pixel : '0;
      out_flag  <= hit;
      out_col   <= hit ? q_col[COORD_W-1:0] : '0;
      out_row   <= hit ? q_row[COORD_W-1:0] : '0;
    end
  end

  assign out_data = {out_row, out_col, out_pixel};
  assign out_user = out_flag;

  assign stat.div_last = (step_cnt == CNT_W'(DIV_STEPS - 1));
  assign stat.out_free = !out_valid || out_ready;

endmodule

>>> src/nngs_ctrl.sv
`timescale 1ns / 1ps

module nngs_ctrl import nngs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_op,
  output logic       in_ready,
  input  ctrl_stat_t stat,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_READ = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Write load beats while idle; sequence one fetch: multiply, divide, read the store, hand over
  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = (state == ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (op_t'(in_op) == OP_FETCH) begin
            cmd.capture = 1'b1;
            state_next  = ST_MUL;
          end else begin
            cmd.load_write = 1'b1;
          end
        end
      end
      ST_MUL: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.mem_read = 1'b1;
        state_next   = ST_FIN;
      end
      ST_FIN: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
